[hdl/wsd_pkg.sv]
// types, constants and helpers shared by the job deque
package wsd_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RING_SIZE   = 2 * QUEUE_DEPTH;
  localparam int CNT_W       = $clog2(RING_SIZE);

  localparam int REQ_W  = 2;
  localparam int JOB_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_STEAL = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [JOB_W-1:0] job_in;
  } in_item_t;

  typedef struct packed {
    logic [JOB_W-1:0]  job_out;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // ring counter to slot index
  function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] s;
    s = (cnt >= CNT_W'(QUEUE_DEPTH)) ? cnt - CNT_W'(QUEUE_DEPTH) : cnt;
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] cnt);
    return (cnt == CNT_W'(RING_SIZE - 1)) ? '0 : cnt + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] cnt);
    return (cnt == '0) ? CNT_W'(RING_SIZE - 1) : cnt - CNT_W'(1);
  endfunction

endpackage

[hdl/work_stealing_deque.sv]
// Double-ended job queue: push and pop at the head, steal at the tail.
//
// Input channel (in_valid / in_stall / in_data): one request per beat,
// req_type push, pop or steal, job_in used by push only.
// Result channel (out_valid / out_stall / out_data): exactly one result
// beat per request, with job_out, status (ok, empty, full) and the number
// of jobs held after the request.
// A result is registered and presented in the cycle after its request is taken.
// Throughput: one request per cycle while the receiver does not stall; each
// request makes one access to the single-port-per-side slot memory (one
// write or one registered read), and the head/tail counters are updated in
// the same cycle, so a pop right after a push reads the slot the push wrote.
// A full queue refuses a push; pop or steal on an empty queue return no job.
// When the receiver stalls, the result register holds and in_stall rises,
// so no request is taken until the result beat leaves.
// Reset (rst_n low, synchronous) empties the queue and drops any result
// beat; slot contents are not cleared and need no clearing pass.
module work_stealing_deque
  import wsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [HANDLE_BITS-1:0] slots [QUEUE_DEPTH];

  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             got_r, got_nxt;
  logic [HANDLE_BITS-1:0] rdata_r;

  logic              accept;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  occ_after;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] waddr, raddr;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign occ = CNT_W'(head_r - tail_r + ((head_r < tail_r) ? CNT_W'(RING_SIZE) : '0));

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = ST_OK;
    got_nxt    = 1'b0;
    occ_after  = occ;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = slot_of(head_r);
    raddr      = slot_of(tail_r);
    case (in_data.req_type)
      REQ_PUSH: begin
        if (occ >= CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          mem_we    = accept;
          head_nxt  = cnt_inc(head_r);
          occ_after = occ + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (occ == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = cnt_dec(head_r);
          raddr     = slot_of(cnt_dec(head_r));
          mem_re    = accept;
          got_nxt   = 1'b1;
          occ_after = occ - CNT_W'(1);
        end
      end
      REQ_STEAL: begin
        if (occ == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          tail_nxt  = cnt_inc(tail_r);
          mem_re    = accept;
          got_nxt   = 1'b1;
          occ_after = occ - CNT_W'(1);
        end
      end
      default: begin
        // unused request code: no change
      end
    endcase
    occ_nxt = OCC_W'(occ_after);
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      occ_r    <= occ_nxt;
      got_r    <= got_nxt;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[waddr] <= HANDLE_BITS'(in_data.job_in);
    end
    if (mem_re) begin
      rdata_r <= slots[raddr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.job_out   = got_r ? JOB_W'(rdata_r) : '0;
  assign out_data.status    = status_r;
  assign out_data.occupancy = occ_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.occupancy <= OCC_W'(QUEUE_DEPTH)))
    else $error("occupancy above queue depth");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL)
      |-> (out_data.occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full status with room left");

  a_empty_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY)
      |-> (out_data.occupancy == '0 && out_data.job_out == '0))
    else $error("empty status with jobs or a handle");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(head_r) && $stable(tail_r)))
    else $error("counters moved without a request");
`endif

endmodule
